// ===== sv/ute_pkg.sv =====
// Shared types, constants and helper functions of the UUID text encoder.
// Used by every module of the block; depends on nothing else.
package ute_pkg;

   typedef enum logic [1:0] {
      FMT_HEX_DASH = 2'd0,
      FMT_HEX      = 2'd1,
      FMT_B62      = 2'd2,
      FMT_B62_HASH = 2'd3
   } text_format_type;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_TEXT_FORMAT = 1'b0;   // register index bit of paddr

   localparam int HALF_W     = 64;
   localparam int HEX_W      = 2 * HALF_W;
   localparam int DIGIT_W    = 6;
   localparam int B62_DIGITS = 11;
   localparam int B62_W      = B62_DIGITS * DIGIT_W;
   localparam int ENTRY_W    = 2 * B62_W;
   localparam int CHUNK_W    = 22;
   localparam int NUM_CHUNKS = 3;
   localparam int VAL_W      = CHUNK_W * NUM_CHUNKS;
   localparam int DIV_IN_W   = DIGIT_W + CHUNK_W;
   localparam int RECIP_W    = 29;
   localparam int RECIP_SH   = 34;
   localparam logic [RECIP_W-1:0] RECIP62 = 29'd277094664;   // floor(2^34 / 62)
   localparam logic [DIV_IN_W-1:0] BASE62 = 28'd62;

   localparam int POS_W     = 6;
   localparam int LEN_DASH  = 36;
   localparam int LEN_HEX   = 32;
   localparam int LEN_B62   = 2 * B62_DIGITS;
   localparam logic [7:0] ASCII_DASH = 8'h2D;

   typedef struct packed {
      logic [HALF_W-1:0] uuid_high;
      logic [HALF_W-1:0] uuid_low;
   } req_type;

   typedef struct packed {
      logic [7:0] text_char;
      logic       last_char;
   } rsp_type;

   // Hex entries use the low 128 bits; base62 entries hold 22 digits, first digit on top.
   typedef struct packed {
      text_format_type    fmt;
      logic [ENTRY_W-1:0] data;
   } entry_type;

   typedef struct packed {
      logic [CHUNK_W-1:0] quot;
      logic [DIGIT_W-1:0] rem;
   } div_type;

   // Divides a remainder-and-chunk value (below 62 * 2^22) by 62.
   function automatic div_type div62_step(input logic [DIV_IN_W-1:0] x);
      logic [DIV_IN_W+RECIP_W-1:0] prod;
      logic [CHUNK_W-1:0]          q;
      logic [DIV_IN_W-1:0]         rm;
      div_type                     res;
      prod = (DIV_IN_W+RECIP_W)'(x) * (DIV_IN_W+RECIP_W)'(RECIP62);
      q    = prod[RECIP_SH +: CHUNK_W];
      rm   = x - (({DIGIT_W'(0), q} << 6) - ({DIGIT_W'(0), q} << 1));
      // The reciprocal estimate is at most one short.
      if (rm >= BASE62) begin
         q  = q + 1'b1;
         rm = rm - BASE62;
      end
      res.quot = q;
      res.rem  = rm[DIGIT_W-1:0];
      return res;
   endfunction

   function automatic logic [7:0] digit_ascii(input logic [DIGIT_W-1:0] d);
      logic [7:0] c;
      if (d < 6'd10) begin
         c = 8'h30 + {2'b00, d};
      end else if (d < 6'd36) begin
         c = 8'h61 + {2'b00, d} - 8'd10;
      end else begin
         c = 8'h41 + {2'b00, d} - 8'd36;
      end
      return c;
   endfunction

endpackage

// ===== sv/ute_b62_lane.sv =====
// Base62 converter for one 64-bit half: computes its 11 digits by chunked division.
// Depends on ute_pkg.
module ute_b62_lane
   import ute_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  logic              convert,
   input  logic [HALF_W-1:0] value,
   output logic              busy,
   output logic [HALF_W-1:0] raw,
   output logic [B62_W-1:0]  digits
);

   logic                busy_ff, busy_in;
   logic [1:0]          chunk_ff, chunk_in;
   logic [3:0]          digit_ff, digit_in;
   logic [DIGIT_W-1:0]  rem_ff, rem_in;
   logic [VAL_W-1:0]    val_ff, val_in;
   logic [DIGIT_W-1:0]  dig_ff [B62_DIGITS];
   logic                last_chunk;
   div_type             step;

   assign step       = div62_step({rem_ff, val_ff[VAL_W-1 -: CHUNK_W]});
   assign last_chunk = (chunk_ff == 2'(NUM_CHUNKS - 1));

   always_comb begin
      busy_in  = busy_ff;
      chunk_in = chunk_ff;
      digit_in = digit_ff;
      rem_in   = rem_ff;
      val_in   = val_ff;
      if (load) begin
         val_in   = {(VAL_W-HALF_W)'(0), value};
         busy_in  = convert;
         chunk_in = '0;
         digit_in = 4'(B62_DIGITS - 1);
         rem_in   = '0;
      end else if (busy_ff) begin
         // The word rotates by one chunk per cycle, so after a full pass over its chunks it holds the quotient.
         val_in = {val_ff[VAL_W-CHUNK_W-1:0], step.quot};
         if (last_chunk) begin
            chunk_in = '0;
            rem_in   = '0;
            if (digit_ff == '0) begin
               busy_in = 1'b0;
            end else begin
               digit_in = digit_ff - 1'b1;
            end
         end else begin
            chunk_in = chunk_ff + 1'b1;
            rem_in   = step.rem;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         chunk_ff <= '0;
         digit_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         chunk_ff <= chunk_in;
         digit_ff <= digit_in;
      end
      rem_ff <= rem_in;
      val_ff <= val_in;
      if (!load && busy_ff && last_chunk) begin
         dig_ff[digit_ff] <= step.rem;
      end
   end

   for (genvar i = 0; i < B62_DIGITS; i++) begin : g_pack
      assign digits[(B62_DIGITS-1-i)*DIGIT_W +: DIGIT_W] = dig_ff[i];
   end

   assign busy = busy_ff;
   assign raw  = val_ff[HALF_W-1:0];

endmodule

// ===== sv/ute_front.sv =====
// Front end: accepts a request, samples the format and runs the base62 lanes.
// Depends on ute_pkg and ute_b62_lane.
module ute_front
   import ute_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  text_format_type format,
   input  logic            req_push,
   output logic            req_full,
   input  req_type         req_data,
   output logic            q_push,
   output entry_type       q_entry,
   input  logic            q_full
);

   logic            valid_ff, valid_in;
   text_format_type fmt_ff, fmt_in;
   logic            accept, convert;
   logic            busy_hi, busy_lo;
   logic [HALF_W-1:0] raw_hi, raw_lo;
   logic [B62_W-1:0]  dig_hi, dig_lo;

   assign convert  = (format == FMT_B62) || (format == FMT_B62_HASH);
   assign q_push   = valid_ff && !busy_hi && !busy_lo && !q_full;
   assign req_full = valid_ff && !q_push;
   assign accept   = req_push && !req_full;

   ute_b62_lane u_lane_hi (
      .clock   (clock),
      .reset   (reset),
      .load    (accept),
      .convert (convert),
      .value   (req_data.uuid_high),
      .busy    (busy_hi),
      .raw     (raw_hi),
      .digits  (dig_hi)
   );

   ute_b62_lane u_lane_lo (
      .clock   (clock),
      .reset   (reset),
      .load    (accept),
      .convert (convert),
      .value   (req_data.uuid_low),
      .busy    (busy_lo),
      .raw     (raw_lo),
      .digits  (dig_lo)
   );

   always_comb begin
      valid_in = valid_ff;
      fmt_in   = fmt_ff;
      if (accept) begin
         valid_in = 1'b1;
         fmt_in   = format;
      end else if (q_push) begin
         valid_in = 1'b0;
      end
   end

   always_comb begin
      q_entry.fmt = fmt_ff;
      if ((fmt_ff == FMT_B62) || (fmt_ff == FMT_B62_HASH)) begin
         q_entry.data = {dig_hi, dig_lo};
      end else begin
         q_entry.data = {(ENTRY_W-HEX_W)'(0), raw_hi, raw_lo};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      fmt_ff <= fmt_in;
   end

endmodule

// ===== sv/ute_queue.sv =====
// Small queue of encoded entries between the front end and the character serializer.
// Depends on ute_pkg.
module ute_queue
   import ute_pkg::*;
#(
   parameter int DEPTH = 2   // 2 to 16
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output entry_type head,
   output logic      empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        slots [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slots[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         slots[wr_ff] <= push_entry;
      end
   end

endmodule

// ===== sv/ute_back.sv =====
// Back end: walks a queued entry, one character per unstalled cycle into the output register.
// Depends on ute_pkg.
module ute_back
   import ute_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  entry_type q_head,
   input  logic      q_empty,
   output logic      q_pop,
   output logic      rsp_empty,
   input  logic      rsp_pop,
   output rsp_type   rsp_data
);

   logic             active_ff, active_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   entry_type        cur_ff;
   logic             out_valid_ff, out_valid_in;
   rsp_type          out_ff, out_in;
   logic             advance, emit, load, last_pos, dash;
   logic [4:0]       nib_idx, dig_idx;
   logic [POS_W-1:0] nib_pos;
   logic [HEX_W-1:0]   hex_sh;
   logic [ENTRY_W-1:0] dig_sh;
   logic [7:0]       char_val;

   // Character selection for the current position.
   always_comb begin
      dash    = 1'b0;
      nib_pos = pos_ff;
      if (cur_ff.fmt == FMT_HEX_DASH) begin
         dash = (pos_ff == 6'd8) || (pos_ff == 6'd13) || (pos_ff == 6'd18) || (pos_ff == 6'd23);
         if (pos_ff > 6'd23) begin
            nib_pos = pos_ff - 6'd4;
         end else if (pos_ff > 6'd18) begin
            nib_pos = pos_ff - 6'd3;
         end else if (pos_ff > 6'd13) begin
            nib_pos = pos_ff - 6'd2;
         end else if (pos_ff > 6'd8) begin
            nib_pos = pos_ff - 6'd1;
         end
      end
      nib_idx = nib_pos[4:0];
      hex_sh  = cur_ff.data[HEX_W-1:0] << {nib_idx, 2'b00};

      // The hashable form lists the first half's digits least significant first.
      if ((cur_ff.fmt == FMT_B62_HASH) && (pos_ff < 6'(B62_DIGITS))) begin
         dig_idx = 5'(B62_DIGITS - 1) - pos_ff[4:0];
      end else begin
         dig_idx = pos_ff[4:0];
      end
      dig_sh = cur_ff.data << (({4'b0, dig_idx} << 2) + ({4'b0, dig_idx} << 1));

      case (cur_ff.fmt)
         FMT_HEX_DASH: begin
            last_pos = (pos_ff == 6'(LEN_DASH - 1));
            char_val = dash ? ASCII_DASH : digit_ascii({2'b00, hex_sh[HEX_W-1 -: 4]});
         end
         FMT_HEX: begin
            last_pos = (pos_ff == 6'(LEN_HEX - 1));
            char_val = digit_ascii({2'b00, hex_sh[HEX_W-1 -: 4]});
         end
         FMT_B62, FMT_B62_HASH: begin
            last_pos = (pos_ff == 6'(LEN_B62 - 1));
            char_val = digit_ascii(dig_sh[ENTRY_W-1 -: DIGIT_W]);
         end
         default: begin
            last_pos = 1'b1;
            char_val = '0;
         end
      endcase
   end

   assign advance = !out_valid_ff || rsp_pop;
   assign emit    = active_ff && advance;
   assign load    = advance && (!active_ff || last_pos) && !q_empty;
   assign q_pop   = load;

   always_comb begin
      active_in    = active_ff;
      pos_in       = pos_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (emit) begin
         out_valid_in     = 1'b1;
         out_in.text_char = char_val;
         out_in.last_char = last_pos;
         pos_in           = pos_ff + 1'b1;
         if (last_pos) begin
            active_in = 1'b0;
         end
      end else if (advance) begin
         out_valid_in = 1'b0;
      end
      if (load) begin
         active_in = 1'b1;
         pos_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         pos_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
      if (load) begin
         cur_ff <= q_head;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ===== sv/uuid_text_encoder_core.sv =====
// UUID text encoder. Each request carries a 128-bit UUID and produces its text, one ASCII
// character per result, with last_char set on the final one. The text_format register
// (address 0) picks hyphenated hex (36 characters), plain hex (32) or base62 (22, optionally
// with the first 11 digits reversed); the format is sampled when a request is accepted.
// The result side delivers one character per cycle while the consumer keeps popping. Base62
// digits come from two 64-bit converters working in parallel, each dividing by 62 one 22-bit
// chunk per cycle, so the division loop in the front end sets the base62 rate. A request is
// accepted while earlier ones are still serialized; its first character passes the front-end
// register, the queue, the back end's entry register and its output register.
module uuid_text_encoder_core
   import ute_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  req_type               req_data,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   text_format_type fmt_ff, fmt_in;
   logic            q_push, q_full, q_pop, q_empty;
   entry_type       q_entry, q_head;
   logic            csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == REG_TEXT_FORMAT);

   always_comb begin
      fmt_in = fmt_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         fmt_in = text_format_type'(csr_pwdata[1:0]);
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_hit) begin
         csr_prdata = {(CSR_DATA_W-2)'(0), fmt_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= FMT_HEX_DASH;
      end else begin
         fmt_ff <= fmt_in;
      end
   end

   ute_front u_front (
      .clock    (clock),
      .reset    (reset),
      .format   (fmt_ff),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_push   (q_push),
      .q_entry  (q_entry),
      .q_full   (q_full)
   );

   ute_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head       (q_head),
      .empty      (q_empty)
   );

   ute_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_head    (q_head),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== sv/ute_checker.sv =====
// Port-level checks for the UUID text encoder, bound to the top level.
// Depends on ute_pkg and uuid_text_encoder_core.
module ute_checker
   import ute_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  logic                  req_full,
   input  logic                  rsp_empty,
   input  logic                  rsp_pop,
   input  rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic [CSR_DATA_W-1:0] csr_prdata,
   input  logic                  csr_pready
);

   // Requests accepted whose final character has not yet been taken.
   logic [7:0] pending_ff, pending_in;
   logic       req_acc, last_acc;

   assign req_acc  = req_push && !req_full;
   assign last_acc = rsp_pop && !rsp_empty && rsp_data.last_char;

   always_comb begin
      pending_in = pending_ff;
      if (req_acc && !last_acc) begin
         pending_in = pending_ff + 1'b1;
      end else if (last_acc && !req_acc) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_reset_idle: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("block not idle after reset");

   a_no_orphan_result: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> pending_ff != '0)
      else $error("result shown with no request outstanding");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
      else $error("waiting result changed or vanished");

   a_format_readback: assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite && csr_pready &&
       csr_paddr[2] == REG_TEXT_FORMAT)
      ##1 (csr_psel && !csr_pwrite && csr_paddr[2] == REG_TEXT_FORMAT)
      |-> csr_prdata == {(CSR_DATA_W-2)'(0), $past(csr_pwdata[1:0])})
      else $error("format register reads back wrong value");

endmodule

bind uuid_text_encoder_core ute_checker u_checker (.*);
